// ----- rtl/rrc_pkg.sv -----
// Shared types and constants for the region RMS color block.
package rrc_pkg;

    localparam int DEF_MAX_DIM     = 1024;
    localparam int DEF_SAMPLE_STEP = 2;
    localparam int DEF_CNT_W       = 19;
    localparam int DEF_SUM_W       = 35;

    localparam int PIXEL_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int DIM_W      = 11;
    localparam int CORNER_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd5;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd240;

    // Red sits in the low byte so the struct maps straight onto tdata.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rrc_color_t;

    typedef struct packed {
        logic       valid;
        logic       busy;
        logic       empty;
        rrc_color_t color;
    } rrc_status_t;

endpackage

// ----- rtl/rrc_rms_unit.sv -----
// Sequenced rounded-RMS unit: one shared multiplier and comparator, one root bit at a time.
module rrc_rms_unit #(
    parameter int CNT_W = rrc_pkg::DEF_CNT_W,
    parameter int SUM_W = rrc_pkg::DEF_SUM_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 empty,
    input  logic [SUM_W-1:0]     red_sum,
    input  logic [SUM_W-1:0]     green_sum,
    input  logic [SUM_W-1:0]     blue_sum,
    input  logic [CNT_W-1:0]     count,
    input  logic                 ack,
    output rrc_pkg::rrc_status_t status
);
    import rrc_pkg::*;

    localparam int MA_W   = 18;
    localparam int MB_W   = (CNT_W > 9) ? CNT_W : 9;
    localparam int PROD_W = MA_W + MB_W;
    localparam int CMP_W  = (PROD_W > SUM_W + 2) ? PROD_W : SUM_W + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] PH_SQ  = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_CMP = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [1:0]        phase_reg;
    logic [1:0]        ch_reg;
    logic [2:0]        bit_reg;
    logic [7:0]        root_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  red_sum_reg;
    logic [SUM_W-1:0]  green_sum_reg;
    logic [SUM_W-1:0]  blue_sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              empty_reg;
    rrc_color_t        color_reg;

    logic [7:0]        cand;
    logic [8:0]        dval;
    logic [SUM_W-1:0]  sum_sel;
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              fits;
    logic [7:0]        root_new;

    // Candidate root with the current bit set; test (2r-1)^2 * count <= 4 * sum.
    assign cand = root_reg | (8'd1 << bit_reg);
    assign dval = {cand, 1'b0} - 9'd1;

    always_comb
    begin
        case (ch_reg)
            CH_RED:   sum_sel = red_sum_reg;
            CH_GREEN: sum_sel = green_sum_reg;
            CH_BLUE:  sum_sel = blue_sum_reg;
            default:  sum_sel = '0;
        endcase
    end

    assign mul_a    = (phase_reg == PH_SQ) ? MA_W'(dval) : prod_reg[MA_W-1:0];
    assign mul_b    = (phase_reg == PH_SQ) ? MB_W'(dval) : MB_W'(cnt_reg);
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign fits     = CMP_W'(prod_reg) <= CMP_W'({sum_sel, 2'b00});
    assign root_new = fits ? cand : root_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = empty ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (phase_reg == PH_CMP && bit_reg == 3'd0 && ch_reg == CH_BLUE)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SQ;
            ch_reg    <= CH_RED;
            bit_reg   <= 3'd7;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                phase_reg <= PH_SQ;
                ch_reg    <= CH_RED;
                bit_reg   <= 3'd7;
            end
            else if (state_reg == ST_RUN)
            begin
                case (phase_reg)
                    PH_SQ:   phase_reg <= PH_MUL;
                    PH_MUL:  phase_reg <= PH_CMP;
                    PH_CMP:
                    begin
                        phase_reg <= PH_SQ;
                        bit_reg   <= bit_reg - 3'd1;
                        if (bit_reg == 3'd0)
                        begin
                            ch_reg <= ch_reg + 2'd1;
                        end
                    end
                    default: phase_reg <= PH_SQ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            red_sum_reg   <= red_sum;
            green_sum_reg <= green_sum;
            blue_sum_reg  <= blue_sum;
            cnt_reg       <= count;
            empty_reg     <= empty;
            root_reg      <= '0;
            color_reg     <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (phase_reg == PH_CMP)
            begin
                if (bit_reg == 3'd0)
                begin
                    root_reg <= '0;
                    case (ch_reg)
                        CH_RED:   color_reg.red   <= root_new;
                        CH_GREEN: color_reg.green <= root_new;
                        CH_BLUE:  color_reg.blue  <= root_new;
                        default:  color_reg       <= color_reg;
                    endcase
                end
                else
                begin
                    root_reg <= root_new;
                end
            end
            else
            begin
                prod_reg <= mul_p;
            end
        end
    end

    assign status.valid = (state_reg == ST_DONE);
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.empty = empty_reg;
    assign status.color = color_reg;

endmodule

// ----- rtl/region_rms_color.sv -----
// Top level: RMS color of a sampled rectangle in an RGB565 pixel stream.
//
// Pixels enter on the s_axis channel in raster order, at most one per cycle, and the
// block counts column and row itself. Pixels inside the clamped rectangle whose
// offsets from its top-left corner are multiples of SAMPLE_STEP are squared per
// channel and summed. After the last pixel of a frame one transaction leaves on
// m_axis: the rounded RMS of red, green and blue in tdata and the empty flag
// in tuser; no other pixel produces output.
// The cfg channel writes the frame size and rectangle registers; it is always
// ready and should only be used between frames.
// Throughput is one pixel per cycle within a frame. After the last pixel the
// input stalls while the sums are handed over, while the shared multiplier and
// comparator find 8 root bits for each of the 3 channels, each bit in 3 steps,
// and until the result moves into the output register, where it is valid from then on.
// An empty rectangle skips that search.
// The result sits in an output register, so pixels of the next frame are
// accepted while it waits; a second frame end stalls until it is taken.
// Reset clears positions, sums and the output valid flag, and loads the default registers.
module region_rms_color #(
    parameter int MAX_DIM     = rrc_pkg::DEF_MAX_DIM,
    parameter int SAMPLE_STEP = rrc_pkg::DEF_SAMPLE_STEP
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // pixel[15:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic [0:0]                       m_axis_tuser,  // region_empty[0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rrc_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int EXT_W = (POS_W + 1 > DIM_W) ? POS_W + 1 : DIM_W;
    localparam int AXIS_N = (MAX_DIM - 1 + SAMPLE_STEP - 1) / SAMPLE_STEP;
    localparam int CNT_W = $clog2(AXIS_N * AXIS_N + 1);
    localparam int SUM_W = CNT_W + 16;
    // Offset alignment by multiply with a rounded-up reciprocal of the step.
    localparam int RSH = POS_W + $clog2(SAMPLE_STEP);
    localparam int RW  = RSH + 1;
    localparam logic [RW-1:0] RECIP = RW'(((1 << RSH) + SAMPLE_STEP - 1) / SAMPLE_STEP);

    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [CORNER_W-1:0] region_left_reg;
    logic [CORNER_W-1:0] region_top_reg;
    logic [CORNER_W-1:0] region_right_reg;
    logic [CORNER_W-1:0] region_bottom_reg;

    logic [POS_W-1:0]    col_reg;
    logic [POS_W-1:0]    row_reg;
    logic                eof_reg;
    logic                samp_reg;
    logic                deg_reg;
    logic [CHAN_W-1:0]   red8_reg;
    logic [CHAN_W-1:0]   green8_reg;
    logic [CHAN_W-1:0]   blue8_reg;
    logic [SUM_W-1:0]    red_sum_reg;
    logic [SUM_W-1:0]    green_sum_reg;
    logic [SUM_W-1:0]    blue_sum_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                out_valid_reg;
    rrc_color_t          out_color_reg;
    logic                out_empty_reg;

    logic [EXT_W-1:0]    w_ext;
    logic [EXT_W-1:0]    h_ext;
    logic [EXT_W-1:0]    w_eff;
    logic [EXT_W-1:0]    h_eff;
    logic [EXT_W-1:0]    wm1;
    logic [EXT_W-1:0]    hm1;
    logic [EXT_W-1:0]    x1;
    logic [EXT_W-1:0]    x2;
    logic [EXT_W-1:0]    y1;
    logic [EXT_W-1:0]    y2;
    logic [EXT_W-1:0]    col_e;
    logic [EXT_W-1:0]    row_e;
    logic                degenerate;
    logic                in_rect;
    logic                sampled;
    logic                last_col;
    logic                last_row;
    logic                in_ready;
    logic                accept;
    logic [15:0]         red_sq;
    logic [15:0]         green_sq;
    logic [15:0]         blue_sq;
    logic                unit_empty;
    logic                unit_ack;
    rrc_status_t         unit_status;

    function automatic logic on_step(input logic [POS_W-1:0] d);
        logic [POS_W+RW-1:0] prod;
        logic [POS_W-1:0]    q;
        prod = (POS_W + RW)'(d) * (POS_W + RW)'(RECIP);
        q    = prod[RSH +: POS_W];
        return d == q * POS_W'(SAMPLE_STEP);
    endfunction

    function automatic logic [EXT_W-1:0] dim_eff(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] r;
        if (v == '0)
        begin
            r = EXT_W'(1);
        end
        else if (v > EXT_W'(MAX_DIM))
        begin
            r = EXT_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [EXT_W-1:0] clamp_hi(input logic [EXT_W-1:0] v,
                                                  input logic [EXT_W-1:0] hi);
        return (v > hi) ? hi : v;
    endfunction

    assign w_ext = EXT_W'(frame_width_reg);
    assign h_ext = EXT_W'(frame_height_reg);
    assign w_eff = dim_eff(w_ext);
    assign h_eff = dim_eff(h_ext);
    assign wm1   = w_eff - EXT_W'(1);
    assign hm1   = h_eff - EXT_W'(1);
    assign x1    = clamp_hi(EXT_W'(region_left_reg), wm1);
    assign x2    = clamp_hi(EXT_W'(region_right_reg), wm1);
    assign y1    = clamp_hi(EXT_W'(region_top_reg), hm1);
    assign y2    = clamp_hi(EXT_W'(region_bottom_reg), hm1);
    assign col_e = EXT_W'(col_reg);
    assign row_e = EXT_W'(row_reg);

    assign degenerate = (x1 >= x2) || (y1 >= y2);
    assign in_rect    = (col_e >= x1) && (col_e < x2) && (row_e >= y1) && (row_e < y2);
    assign sampled    = !degenerate && in_rect
                        && on_step(POS_W'(col_e - x1)) && on_step(POS_W'(row_e - y1));
    assign last_col   = col_e >= wm1;
    assign last_row   = row_e >= hm1;

    assign in_ready      = !eof_reg && !unit_status.busy;
    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;
    assign cfg_ready     = 1'b1;

    assign red_sq   = red8_reg * red8_reg;
    assign green_sq = green8_reg * green8_reg;
    assign blue_sq  = blue8_reg * blue8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= '0;
            region_bottom_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                REG_REGION_LEFT:   region_left_reg   <= cfg_data[CORNER_W-1:0];
                REG_REGION_TOP:    region_top_reg    <= cfg_data[CORNER_W-1:0];
                REG_REGION_RIGHT:  region_right_reg  <= cfg_data[CORNER_W-1:0];
                REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[CORNER_W-1:0];
                default:           frame_width_reg   <= frame_width_reg;
            endcase
        end
    end

    // Position tracking and the sampling decision happen on acceptance; the
    // squares are added in the cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            eof_reg       <= 1'b0;
            samp_reg      <= 1'b0;
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            samp_reg <= accept && sampled;
            eof_reg  <= accept && last_col && last_row;
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end
            // The frame's last pixel is never sampled, so the sums are final here.
            if (eof_reg)
            begin
                red_sum_reg   <= '0;
                green_sum_reg <= '0;
                blue_sum_reg  <= '0;
                count_reg     <= '0;
            end
            else if (samp_reg)
            begin
                red_sum_reg   <= red_sum_reg + SUM_W'(red_sq);
                green_sum_reg <= green_sum_reg + SUM_W'(green_sq);
                blue_sum_reg  <= blue_sum_reg + SUM_W'(blue_sq);
                count_reg     <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red8_reg   <= {s_axis_tdata[15:11], 3'b000};
            green8_reg <= {s_axis_tdata[10:5], 2'b00};
            blue8_reg  <= {s_axis_tdata[4:0], 3'b000};
            deg_reg    <= degenerate;
        end
    end

    assign unit_empty = deg_reg || (count_reg == '0);
    assign unit_ack   = unit_status.valid && (!out_valid_reg || m_axis_tready);

    rrc_rms_unit #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_rms (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eof_reg),
        .empty     (unit_empty),
        .red_sum   (red_sum_reg),
        .green_sum (green_sum_reg),
        .blue_sum  (blue_sum_reg),
        .count     (count_reg),
        .ack       (unit_ack),
        .status    (unit_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (unit_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (unit_ack)
        begin
            out_color_reg <= unit_status.color;
            out_empty_reg <= unit_status.empty;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_color_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule

// ----- rtl/rrc_checker.sv -----
// Port-level assertions for the region RMS color block and their binding.
module rrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        cfg_ready
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An empty rectangle reports black.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
        else $error("empty region with nonzero color");

    // The input only closes right after a pixel transaction ends a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input stalled without a preceding transaction");

    // A new result appears only after the input was held off for the computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a computation phase");

    // The configuration channel never back-pressures.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind region_rms_color rrc_checker u_rrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_ready     (cfg_ready)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for region_rms_color: predicted RMS colors compared per frame.
`timescale 1ns / 100ps

module tb_top;
    import rrc_pkg::*;

    localparam int MAX_DIM       = DEF_MAX_DIM;
    localparam int SAMPLE_STEP   = DEF_SAMPLE_STEP;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PIXELS = 500;
    localparam int RANDOM_FRAMES = 20;

    typedef struct {
        rrc_color_t color;
        logic       empty;
    } rms_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIXEL_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copy, loaded with the reset values of the block.
    logic [DIM_W-1:0]    width_reg = RST_FRAME_WIDTH;
    logic [DIM_W-1:0]    height_reg = RST_FRAME_HEIGHT;
    logic [CORNER_W-1:0] left_reg = '0;
    logic [CORNER_W-1:0] top_reg = '0;
    logic [CORNER_W-1:0] right_reg = '0;
    logic [CORNER_W-1:0] bottom_reg = '0;

    // Frame accumulation state of the predictor.
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    longint unsigned   red_sq_sum = 0;
    longint unsigned   green_sq_sum = 0;
    longint unsigned   blue_sq_sum = 0;
    longint unsigned   sample_total = 0;

    rms_result_t rms_expected[$];
    rms_result_t want;
    rrc_color_t  seen;

    int error_count = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int stall_left = 0;
    bit frame_closed = 1'b0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    region_rms_color dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0) return 16'hFFFF;
        if (roll == 1) return 16'h0000;
        return PIXEL_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic int unsigned saturated_dim(input logic [DIM_W-1:0] value);
        if (value == 0) return 1;
        if (value > MAX_DIM) return MAX_DIM;
        return value;
    endfunction

    // Largest r in 0..255 with (2r-1)^2 * n <= 4 * sum, i.e. sqrt(sum/n) rounded half up.
    function automatic logic [CHAN_W-1:0] rounded_rms(input longint unsigned sum,
                                                      input longint unsigned n);
        longint unsigned lo, hi, mid, odd;
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * n <= 4 * sum) lo = mid;
            else hi = mid - 1;
        end
        return lo[CHAN_W-1:0];
    endfunction

    function automatic void accumulate_pixel(input logic [PIXEL_W-1:0] pix);
        int unsigned     w, h, x1, x2, y1, y2;
        bit              degenerate;
        longint unsigned r, g, b;
        rms_result_t     res;
        w = saturated_dim(width_reg);
        h = saturated_dim(height_reg);
        x1 = (left_reg > w - 1) ? w - 1 : left_reg;
        x2 = (right_reg > w - 1) ? w - 1 : right_reg;
        y1 = (top_reg > h - 1) ? h - 1 : top_reg;
        y2 = (bottom_reg > h - 1) ? h - 1 : bottom_reg;
        degenerate = (x1 >= x2) || (y1 >= y2);
        frame_closed = 1'b0;
        if (!degenerate && col_pos >= x1 && col_pos < x2 && row_pos >= y1 && row_pos < y2
            && ((col_pos - x1) % SAMPLE_STEP) == 0 && ((row_pos - y1) % SAMPLE_STEP) == 0)
        begin
            r = pix[15:11];
            g = pix[10:5];
            b = pix[4:0];
            r = r << 3;
            g = g << 2;
            b = b << 3;
            red_sq_sum += r * r;
            green_sq_sum += g * g;
            blue_sq_sum += b * b;
            sample_total += 1;
        end
        if (col_pos < w - 1)
        begin
            col_pos = col_pos + 1;
            return;
        end
        col_pos = 0;
        if (row_pos < h - 1)
        begin
            row_pos = row_pos + 1;
            return;
        end
        // Last pixel of the frame: one result, then a fresh accumulation.
        if (degenerate || sample_total == 0)
        begin
            res.color = '0;
            res.empty = 1'b1;
        end
        else
        begin
            res.color.red = rounded_rms(red_sq_sum, sample_total);
            res.color.green = rounded_rms(green_sq_sum, sample_total);
            res.color.blue = rounded_rms(blue_sq_sum, sample_total);
            res.empty = 1'b0;
        end
        rms_expected.insert(rms_expected.size(), res);
        row_pos = 0;
        red_sq_sum = 0;
        green_sq_sum = 0;
        blue_sq_sum = 0;
        sample_total = 0;
        frame_closed = 1'b1;
    endfunction

    // Valid stays high after a transaction so back-to-back pixels need no gap.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        int gap;
        gap = gaps_on ? draw_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        accumulate_pixel(pix);
        pixels_sent++;
    endtask

    task automatic send_frame();
        do send_pixel(random_pixel()); while (!frame_closed);
    endtask

    // Waits until the block is idle: no result outstanding, root search finished.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (rms_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:   width_reg = value;
            REG_FRAME_HEIGHT:  height_reg = value;
            REG_REGION_LEFT:   left_reg = value[CORNER_W-1:0];
            REG_REGION_TOP:    top_reg = value[CORNER_W-1:0];
            REG_REGION_RIGHT:  right_reg = value[CORNER_W-1:0];
            REG_REGION_BOTTOM: bottom_reg = value[CORNER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic set_region(input int l, input int t, input int r, input int b);
        write_reg(REG_REGION_LEFT, CFG_DATA_W'(l));
        write_reg(REG_REGION_TOP, CFG_DATA_W'(t));
        write_reg(REG_REGION_RIGHT, CFG_DATA_W'(r));
        write_reg(REG_REGION_BOTTOM, CFG_DATA_W'(b));
    endtask

    function automatic int random_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(7, 2);
        if (roll < 90) return $urandom_range(1);
        return $urandom_range(16, 8);
    endfunction

    function automatic int random_corner(input int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return $urandom_range(span);
        if (roll < 88) return 1023;
        return $urandom_range(2047);
    endfunction

    task automatic random_setup();
        int w, h, x1, y1;
        w = random_dim();
        h = random_dim();
        if ($urandom_range(4) != 0) write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        if ($urandom_range(4) != 0) write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        if ($urandom_range(9) < 6)
        begin
            // Ordered corners, so most frames actually sample something.
            x1 = $urandom_range(w > 1 ? w - 2 : 0);
            y1 = $urandom_range(h > 1 ? h - 2 : 0);
            set_region(x1, y1, $urandom_range(w + 1, x1 + 1), $urandom_range(h + 1, y1 + 1));
        end
        else
        begin
            if ($urandom_range(3) != 0)
                write_reg(REG_REGION_LEFT, CFG_DATA_W'(random_corner(w + 1)));
            if ($urandom_range(3) != 0)
                write_reg(REG_REGION_TOP, CFG_DATA_W'(random_corner(h + 1)));
            if ($urandom_range(3) != 0)
                write_reg(REG_REGION_RIGHT, CFG_DATA_W'(random_corner(w + 1)));
            if ($urandom_range(3) != 0)
                write_reg(REG_REGION_BOTTOM, CFG_DATA_W'(random_corner(h + 1)));
        end
    endtask

    // Only frame size is written, so the rectangle keeps its all-zero reset corners.
    task automatic test_reset_corners();
        set_frame(2, 2);
        send_frame();
    endtask

    task automatic test_channel_extremes();
        settle();
        set_frame(2, 2);
        set_region(0, 0, 1, 1);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        // A sampled black pixel gives zero color but is not flagged empty.
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
    endtask

    task automatic test_degenerate_and_saturation();
        settle();
        set_frame(0, 0);
        send_frame();
        settle();
        set_frame(2, 2);
        set_region(1, 0, 0, 1);
        send_frame();
    endtask

    task automatic test_midframe_change();
        settle();
        set_frame(3, 3);
        set_region(0, 0, 2, 2);
        repeat (4) send_pixel(random_pixel());
        settle();
        // The position is now on the new last column, so the row ends at the next pixel.
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        send_frame();
        settle();
        set_frame(2, 3);
        set_region(0, 1, 1, 2);
        send_pixel(random_pixel());
        settle();
        // The rectangle moves behind the current position: nothing gets sampled.
        write_reg(REG_REGION_TOP, CFG_DATA_W'(0));
        write_reg(REG_REGION_BOTTOM, CFG_DATA_W'(1));
        send_frame();
    endtask

    task automatic test_random_frames();
        int first_pixel, first_result;
        first_pixel = pixels_sent;
        first_result = results_seen;
        while (pixels_sent - first_pixel < RANDOM_PIXELS
               || results_seen - first_result < RANDOM_FRAMES)
        begin
            settle();
            gaps_on = ($urandom_range(3) != 0);
            stalls_on = ($urandom_range(3) != 0);
            random_setup();
            if ($urandom_range(5) == 0)
            begin
                repeat ($urandom_range(6, 1)) send_pixel(random_pixel());
                settle();
                random_setup();
            end
            repeat ($urandom_range(4, 1)) send_frame();
        end
    endtask

    // Oversized frame and corner values, cut short by shrinking the frame mid-run.
    task automatic test_large_frames();
        settle();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        set_frame(2047, 2047);
        set_region(1, 1, 1023, 1023);
        repeat (12) send_pixel(random_pixel());
        settle();
        // The long first row ends at the next pixel.
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
        repeat (6) send_pixel(random_pixel());
        settle();
        // The row position is past the new last row, so this row ends the frame.
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        send_frame();
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (stalls_on) stall_left = draw_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (rms_expected.size() == 0)
            begin
                $error("result transaction with no frame outstanding: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = rms_expected.pop_front();
                seen = m_axis_tdata;
                if (seen.red !== want.color.red)
                begin
                    $error("red: expected %0d, got %0d", want.color.red, seen.red);
                    error_count++;
                end
                if (seen.green !== want.color.green)
                begin
                    $error("green: expected %0d, got %0d", want.color.green, seen.green);
                    error_count++;
                end
                if (seen.blue !== want.color.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.color.blue, seen.blue);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.empty)
                begin
                    $error("region_empty: expected %0d, got %0d", want.empty, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_corners();
        test_channel_extremes();
        test_degenerate_and_saturation();
        test_midframe_change();
        test_random_frames();
        test_large_frames();
        settle();
        if (error_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
